// ===== rtl/csq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csq_pkg: shared types and codes for the semaphore wait queue
// Opcodes, result event codes, controller actions and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package csq_pkg;

  localparam int THREADS_DEF = 16;
  localparam int OP_W        = 2;
  localparam int THREAD_W    = 4;
  localparam int EVENT_W     = 3;
  localparam int COUNT_W     = 8;
  localparam int ACT_W       = 3;

  // input opcodes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // result event codes
  localparam logic [EVENT_W-1:0] EV_GRANTED       = 3'd0;
  localparam logic [EVENT_W-1:0] EV_QUEUED        = 3'd1;
  localparam logic [EVENT_W-1:0] EV_WOKEN         = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TIMED_OUT     = 3'd3;
  localparam logic [EVENT_W-1:0] EV_GRANT_BEFORE  = 3'd4;
  localparam logic [EVENT_W-1:0] EV_RELEASED      = 3'd5;
  localparam logic [EVENT_W-1:0] EV_UNDERFLOW     = 3'd6;
  localparam logic [EVENT_W-1:0] EV_DUPLICATE     = 3'd7;

  // controller actions
  localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ACQUIRE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WAKE_RD     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_WAKE        = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SCAN        = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SCAN_END    = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NOT_WAITING = 3'd7;

  typedef struct packed {
    logic             load;
    logic [ACT_W-1:0] act;
  } csq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            flag_t;
    logic            hold_zero;
    logic            wake_after_rel;
    logic            wake_more;
    logic            scan_done;
  } csq_sts_t;

endpackage
`default_nettype wire

// ===== rtl/counting_semaphore_wait_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_core: counting semaphore with FIFO waiters
// Command port: a word {op, thread_id} is taken at a clock edge with start
// high and busy low. op 0 acquires, 1 releases, 2 reports a wait timeout.
// Results: each result word is on event_kind/subject_thread/holder_count/last
// for exactly one cycle with strobe high; last marks the final word of an
// operation. The receiver has no way to stall; it must take every strobe.
// Config: cfg_we/cfg_data write max_holders (reset 1); write only while idle.
// Sequence: acquire, underflow and timeout of a non-waiter strobe their word
// from the decode state. Release strobes its word, then does a head read and
// a wake for each woken thread. Timeout of a waiter runs the one-port-read
// compaction scan through the waiter ring memory before its word. busy stays
// high until the operation ends, so no new word is taken before that.
// Reset (rst, synchronous): holders and queue length zero, all waiting
// flags clear, max_holders = 1. The waiter memory is not cleared; only
// slots holding queued threads are ever read.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_core #(
  parameter int THREADS = csq_pkg::THREADS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [csq_pkg::OP_W-1:0]         op,
  input  wire logic [csq_pkg::THREAD_W-1:0]     thread_id,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [csq_pkg::COUNT_W-1:0]      cfg_data,
  // result channel
  output logic                                  strobe,
  output logic [csq_pkg::EVENT_W-1:0]           event_kind,
  output logic [csq_pkg::THREAD_W-1:0]          subject_thread,
  output logic [csq_pkg::COUNT_W-1:0]           holder_count,
  output logic                                  last
);

  // controller <-> datapath handshake bundles
  csq_pkg::csq_cmd_t cmd;
  csq_pkg::csq_sts_t sts;

  // sequencer: decode, wake loop, compaction scan
  csq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // state, waiter ring memory and registered result word
  csq_datapath #(
    .THREADS (THREADS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .op             (op),
    .thread_id      (thread_id),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .event_kind     (event_kind),
    .subject_thread (subject_thread),
    .holder_count   (holder_count),
    .last           (last)
  );

endmodule
`default_nettype wire

// ===== rtl/csq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csq_ctrl: sequencer for the semaphore wait queue
// Steps one operation at a time: decode, wake loop, queue compaction scan.
// ----------------------------------------------------------------------------
module csq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire csq_pkg::csq_sts_t sts,
  output csq_pkg::csq_cmd_t      cmd,
  output logic                   busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_WAKE_RD = 3'd2;
  localparam logic [2:0] S_WAKE    = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [csq_pkg::ACT_W-1:0] act;

  always_comb begin
    state_next = state;
    act        = csq_pkg::ACT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        unique case (sts.op)
          csq_pkg::OP_ACQUIRE: act = csq_pkg::ACT_ACQUIRE;
          csq_pkg::OP_RELEASE: begin
            act = csq_pkg::ACT_RELEASE;
            if (!sts.hold_zero && sts.wake_after_rel) state_next = S_WAKE_RD;
          end
          csq_pkg::OP_TIMEOUT: begin
            if (sts.flag_t) state_next = S_SCAN;
            else act = csq_pkg::ACT_NOT_WAITING;
          end
          default: ;  // unused opcode, no result
        endcase
      end
      S_WAKE_RD: begin
        act        = csq_pkg::ACT_WAKE_RD;
        state_next = S_WAKE;
      end
      S_WAKE: begin
        act        = csq_pkg::ACT_WAKE;
        state_next = sts.wake_more ? S_WAKE_RD : S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          act        = csq_pkg::ACT_SCAN_END;
          state_next = S_IDLE;
        end else begin
          act = csq_pkg::ACT_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.act  = act;

  // a wake always follows its head read
  a_wake_after_read: assert property (@(posedge clk) disable iff (rst)
    act == csq_pkg::ACT_WAKE |-> $past(act) == csq_pkg::ACT_WAKE_RD)
    else $error("wake without head read");

  // no new item is loaded while the wake loop or scan runs
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC)
    else $error("load did not enter decode");

endmodule
`default_nettype wire

// ===== rtl/csq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csq_datapath: counters, waiting flags, waiter ring and result register
// The waiter queue is a ring in a one-read one-write memory; timeouts
// compact it in place with a streaming read/write scan.
// ----------------------------------------------------------------------------
module csq_datapath #(
  parameter int THREADS = csq_pkg::THREADS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire csq_pkg::csq_cmd_t               cmd,
  output csq_pkg::csq_sts_t                    sts,
  input  wire logic [csq_pkg::OP_W-1:0]        op,
  input  wire logic [csq_pkg::THREAD_W-1:0]    thread_id,
  input  wire logic                            cfg_we,
  input  wire logic [csq_pkg::COUNT_W-1:0]     cfg_data,
  output logic                                 strobe,
  output logic [csq_pkg::EVENT_W-1:0]          event_kind,
  output logic [csq_pkg::THREAD_W-1:0]         subject_thread,
  output logic [csq_pkg::COUNT_W-1:0]          holder_count,
  output logic                                 last
);

  localparam int AW     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CW     = $clog2(THREADS + 1);
  localparam int QDEPTH = 1 << AW;
  localparam int TW     = csq_pkg::THREAD_W;
  localparam int HW     = csq_pkg::COUNT_W;

  logic [HW-1:0]      max_holders;
  logic [HW-1:0]      holders;
  logic [CW-1:0]      len;
  logic [AW-1:0]      head;
  logic [THREADS-1:0] flags;
  logic [csq_pkg::OP_W-1:0] op_lat;
  logic [TW-1:0]      t_lat;
  logic [TW-1:0]      t_red;
  logic [CW-1:0]      scan_i;
  logic [CW-1:0]      scan_j;
  logic               rd_pend;

  logic [TW-1:0] qmem [QDEPTH];
  logic [TW-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [TW-1:0] wdata;

  logic [AW-1:0] t_idx;
  logic [AW-1:0] w_idx;
  logic          flag_t;
  logic          room;
  logic          below_max;

  // thread_id modulo THREADS by repeated compare-subtract (quotient at most 8)
  always_comb begin
    t_red = thread_id;
    for (int k = 0; k < 8; k++) begin
      if (int'(t_red) >= THREADS) t_red = t_red - TW'(THREADS);
    end
  end

  assign t_idx     = AW'(t_lat);
  assign w_idx     = AW'(rdata);
  assign flag_t    = flags[t_idx];
  assign room      = int'(len) < THREADS;
  assign below_max = holders < max_holders;

  assign sts.op             = op_lat;
  assign sts.flag_t         = flag_t;
  assign sts.hold_zero      = (holders == '0);
  assign sts.wake_after_rel = (len != '0) && ((holders - HW'(1)) < max_holders);
  assign sts.wake_more      = (len > CW'(1)) &&
                              (({1'b0, holders} + (HW+1)'(1)) < {1'b0, max_holders});
  assign sts.scan_done      = (scan_i == len) && !rd_pend;

  // memory port control; the scan moves kept entries down toward the head
  always_comb begin
    rd_en = 1'b0;
    raddr = head;
    wr_en = 1'b0;
    waddr = head + AW'(len);
    wdata = t_lat;
    unique case (cmd.act)
      csq_pkg::ACT_ACQUIRE: wr_en = !flag_t && !below_max && room;
      csq_pkg::ACT_WAKE_RD: rd_en = 1'b1;
      csq_pkg::ACT_SCAN: begin
        rd_en = (scan_i != len);
        raddr = head + AW'(scan_i);
        wr_en = rd_pend && (rdata != t_lat);
        waddr = head + AW'(scan_j);
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= qmem[raddr];
    if (wr_en) qmem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_holders <= HW'(1);
      holders     <= '0;
      len         <= '0;
      head        <= '0;
      flags       <= '0;
      rd_pend     <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) max_holders <= cfg_data;
      if (cmd.load) begin
        op_lat  <= op;
        t_lat   <= t_red;
        scan_i  <= '0;
        scan_j  <= '0;
        rd_pend <= 1'b0;
      end
      unique case (cmd.act)
        csq_pkg::ACT_ACQUIRE: begin
          strobe         <= 1'b1;
          subject_thread <= t_lat;
          last           <= 1'b1;
          holder_count   <= holders;
          if (flag_t) begin
            event_kind <= csq_pkg::EV_DUPLICATE;
          end else if (below_max) begin
            event_kind   <= csq_pkg::EV_GRANTED;
            holders      <= holders + HW'(1);
            holder_count <= holders + HW'(1);
          end else begin
            event_kind <= csq_pkg::EV_QUEUED;
            if (room) begin
              len          <= len + CW'(1);
              flags[t_idx] <= 1'b1;
            end
          end
        end
        csq_pkg::ACT_RELEASE: begin
          strobe         <= 1'b1;
          subject_thread <= t_lat;
          if (holders == '0) begin
            event_kind   <= csq_pkg::EV_UNDERFLOW;
            holder_count <= holders;
            last         <= 1'b1;
          end else begin
            event_kind   <= csq_pkg::EV_RELEASED;
            holders      <= holders - HW'(1);
            holder_count <= holders - HW'(1);
            last         <= !sts.wake_after_rel;
          end
        end
        csq_pkg::ACT_WAKE: begin
          strobe         <= 1'b1;
          event_kind     <= csq_pkg::EV_WOKEN;
          subject_thread <= rdata;
          holders        <= holders + HW'(1);
          holder_count   <= holders + HW'(1);
          last           <= !sts.wake_more;
          head           <= head + AW'(1);
          len            <= len - CW'(1);
          flags[w_idx]   <= 1'b0;
        end
        csq_pkg::ACT_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) scan_i <= scan_i + CW'(1);
          if (wr_en) scan_j <= scan_j + CW'(1);
        end
        csq_pkg::ACT_SCAN_END: begin
          strobe         <= 1'b1;
          event_kind     <= csq_pkg::EV_TIMED_OUT;
          subject_thread <= t_lat;
          holder_count   <= holders;
          last           <= 1'b1;
          len            <= scan_j;
          flags[t_idx]   <= 1'b0;
        end
        csq_pkg::ACT_NOT_WAITING: begin
          strobe         <= 1'b1;
          event_kind     <= csq_pkg::EV_GRANT_BEFORE;
          subject_thread <= t_lat;
          holder_count   <= holders;
          last           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // every queued thread has exactly one flag set
  a_flags_match_len: assert property (@(posedge clk) disable iff (rst)
    $countones(flags) == int'(len))
    else $error("waiting flags out of step with queue length");

  // compaction never overwrites the slot being read
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> waddr != raddr)
    else $error("queue read/write address clash");

  // compaction write pointer trails the read pointer
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    cmd.act == csq_pkg::ACT_SCAN |-> scan_j <= scan_i)
    else $error("scan write pointer ahead of read pointer");

endmodule
`default_nettype wire

// ===== tb/counting_semaphore_wait_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_core_tb: self-checking bench for the semaphore
// Drives acquire, release and timeout words through the start/busy port. The
// bench mirrors the holder count, the FIFO of waiters and the waiting flags,
// and it checks every strobed result word against the events predicted for
// the words taken so far. It steps through several max_holders settings, 0
// and 255 among them.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_core_tb;
  import csq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;   // longer than any scan through the ring
  localparam int PHASE_WORDS = 35;

  // one predicted result word
  typedef struct packed {
    logic [EVENT_W-1:0]  kind;
    logic [THREAD_W-1:0] who;
    logic [COUNT_W-1:0]  count;
    logic                fin;
  } sem_event_t;

  // Holds the semaphore state as the block should see it and the result
  // words still owed by the block, oldest first.
  class sem_scoreboard;
    sem_event_t          due_events[$];
    logic [COUNT_W-1:0]  max_holders;
    logic [COUNT_W-1:0]  holders;
    logic [THREAD_W-1:0] waiters[$];
    logic [THREADS_DEF-1:0] waiting;
    int                  errors;

    function new();
      max_holders = 8'd1;
      holders = '0;
      waiting = '0;
      errors = 0;
    endfunction

    function void set_limit(logic [COUNT_W-1:0] value);
      max_holders = value;
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    function void add_event(logic [EVENT_W-1:0] kind, logic [THREAD_W-1:0] who);
      sem_event_t ev;
      ev.kind = kind;
      ev.who = who;
      ev.count = holders;
      ev.fin = 1'b0;
      due_events.push_back(ev);
    endfunction

    // Works out the result words for one accepted command word.
    function void note_word(logic [OP_W-1:0] opc, logic [THREAD_W-1:0] tid);
      int first;
      logic [THREAD_W-1:0] head;
      logic [THREAD_W-1:0] kept[$];
      sem_event_t tail;
      first = due_events.size();
      case (opc)
        OP_ACQUIRE: begin
          if (waiting[tid]) begin
            add_event(EV_DUPLICATE, tid);
          end else if (holders < max_holders) begin
            holders++;
            add_event(EV_GRANTED, tid);
          end else begin
            if (waiters.size() < THREADS_DEF) begin
              waiters.push_back(tid);
              waiting[tid] = 1'b1;
            end
            add_event(EV_QUEUED, tid);
          end
        end
        OP_RELEASE: begin
          if (holders == 0) begin
            add_event(EV_UNDERFLOW, tid);
          end else begin
            holders--;
            add_event(EV_RELEASED, tid);
            while (waiters.size() > 0 && holders < max_holders) begin
              head = waiters.pop_front();
              waiting[head] = 1'b0;
              holders++;
              add_event(EV_WOKEN, head);
            end
          end
        end
        OP_TIMEOUT: begin
          if (waiting[tid]) begin
            foreach (waiters[i])
              if (waiters[i] != tid) kept.push_back(waiters[i]);
            waiters = kept;
            waiting[tid] = 1'b0;
            add_event(EV_TIMED_OUT, tid);
          end else begin
            add_event(EV_GRANT_BEFORE, tid);
          end
        end
        default: ;  // unused opcode: no result
      endcase
      if (due_events.size() > first) begin
        tail = due_events.pop_back();
        tail.fin = 1'b1;
        due_events.push_back(tail);
      end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [EVENT_W-1:0] kind, logic [THREAD_W-1:0] who,
                             logic [COUNT_W-1:0] count, logic fin);
      sem_event_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %0d thread %0d count %0d last %0b",
                 $time, kind, who, count, fin);
        errors++;
        return;
      end
      want = due_events.pop_front();
      cmp_field("event_kind", 8'(want.kind), 8'(kind));
      cmp_field("subject_thread", 8'(want.who), 8'(who));
      cmp_field("holder_count", want.count, count);
      cmp_field("last", 8'(want.fin), 8'(fin));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     op;
  logic [THREAD_W-1:0] thread_id;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_data;
  logic                strobe;
  logic [EVENT_W-1:0]  event_kind;
  logic [THREAD_W-1:0] subject_thread;
  logic [COUNT_W-1:0]  holder_count;
  logic                last;

  sem_scoreboard sb = new();
  bit gaps_on = 1'b1;   // random idle cycles on the command side
  int cycle_count = 0;

  counting_semaphore_wait_queue_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .thread_id      (thread_id),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .event_kind     (event_kind),
    .subject_thread (subject_thread),
    .holder_count   (holder_count),
    .last           (last)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitors sample at the rising edge; the values seen are the ones that
  // held through the cycle, since the block updates with nonblocking writes.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_limit(cfg_data);
      if (start && !busy) sb.note_word(op, thread_id);
      if (strobe) sb.check_word(event_kind, subject_thread, holder_count, last);
    end
  end

  // watchdog: a hung handshake or a missing result word ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("counting_semaphore_wait_queue_core verification failed");
      $finish;
    end
  end

  // Presents one command word from the falling edge and holds it until an
  // edge with busy low takes it. Idle cycles in front drop start and put
  // junk on the payload.
  task automatic send_word(input logic [OP_W-1:0] opc, input logic [THREAD_W-1:0] tid);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 17) begin
      start <= 1'b0;
      op <= OP_W'($urandom);
      thread_id <= THREAD_W'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    op <= opc;
    thread_id <= tid;
    do @(posedge clk); while (busy);
  endtask

  // Drops start, waits for every owed result word, then lets an unused
  // opcode or a trailing scan run out before the block is treated as idle.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [COUNT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int lim;
    int acq_pct;
    int r;
    logic [OP_W-1:0] opc;
    logic [THREAD_W-1:0] tid;

    rst = 1'b1;
    start = 1'b0;
    op = OP_ACQUIRE;
    thread_id = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, max_holders at its reset value of 1 ----
    send_word(OP_RELEASE, 4'd0);   // release with nobody holding: underflow
    send_word(OP_ACQUIRE, 4'd0);   // granted, count 1
    send_word(OP_ACQUIRE, 4'd5);   // full: queued
    send_word(OP_ACQUIRE, 4'd5);   // already waiting: duplicate
    send_word(OP_ACQUIRE, 4'd15);
    send_word(OP_ACQUIRE, 4'd9);   // queue now 5, 15, 9
    send_word(OP_TIMEOUT, 4'd15);  // removed from the middle
    send_word(OP_TIMEOUT, 4'd15);  // no longer waiting
    send_word(OP_TIMEOUT, 4'd3);   // never waited
    send_word(2'd3, 4'd10);        // unused opcode, no result
    send_word(OP_RELEASE, 4'd0);   // release, then head 5 woken
    send_word(OP_RELEASE, 4'd5);   // release, then 9 woken
    send_word(OP_RELEASE, 4'd9);   // count back to zero, queue empty

    write_max(8'd3);
    send_word(OP_ACQUIRE, 4'd1);
    send_word(OP_ACQUIRE, 4'd2);
    send_word(OP_ACQUIRE, 4'd3);
    send_word(OP_ACQUIRE, 4'd4);
    send_word(OP_ACQUIRE, 4'd6);
    send_word(OP_ACQUIRE, 4'd12);
    send_word(OP_TIMEOUT, 4'd12);  // tail removal
    send_word(OP_TIMEOUT, 4'd4);   // head removal
    send_word(OP_ACQUIRE, 4'd10);
    send_word(OP_ACQUIRE, 4'd11);  // queue 6, 10, 11

    // raised limit: one release wakes the whole queue
    write_max(8'd255);
    send_word(OP_RELEASE, 4'd1);

    // limit dropped under the count: acquires queue, releases wake nobody
    write_max(8'd0);
    send_word(OP_ACQUIRE, 4'd7);
    send_word(OP_RELEASE, 4'd2);
    send_word(OP_TIMEOUT, 4'd7);

    // ---- random part: one limit per phase, with its own op mix ----
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lim = 2;   acq_pct = 55; end
        1: begin lim = 0;   acq_pct = 45; end
        2: begin lim = 1;   acq_pct = 75; end  // builds a deep queue
        3: begin lim = 255; acq_pct = 35; end  // first release empties it
        4: begin lim = $urandom_range(4, 254); acq_pct = 50; end
        5: begin lim = 1;   acq_pct = 25; end  // drains toward underflow
        6: begin lim = 3;   acq_pct = 60; end
        default: begin lim = 8; acq_pct = 45; end
      endcase
      write_max(COUNT_W'(lim));
      gaps_on = (p != 6);  // one phase runs back to back
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(99);
        tid = THREAD_W'($urandom_range(15));
        if (r < acq_pct) begin
          opc = OP_ACQUIRE;
        end else if (r < acq_pct + (95 - acq_pct) * 2 / 3) begin
          opc = OP_RELEASE;
        end else if (r < 95) begin
          opc = OP_TIMEOUT;
          // mostly aim timeouts at threads that are really waiting
          if (sb.waiters.size() > 0 && $urandom_range(9) < 7)
            tid = sb.waiters[$urandom_range(sb.waiters.size() - 1)];
        end else begin
          opc = 2'd3;
        end
        send_word(opc, tid);
      end
    end
    gaps_on = 1'b1;

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("counting_semaphore_wait_queue_core verification clean");
    else
      $display("counting_semaphore_wait_queue_core verification failed");
    $finish;
  end

endmodule
